>>> hdl/bffa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bffa_pkg;

  // Bitmap geometry
  localparam int MAP_BITS  = 32768;
  localparam int WORD_BITS = 32;
  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int IDX_W     = 15;
  localparam int CNT_W     = 16;
  localparam int NWORD_W   = ADDR_W + 1;

  // Command codes
  localparam logic [1:0] CMD_FIND  = 2'd0;
  localparam logic [1:0] CMD_MARK  = 2'd1;
  localparam logic [1:0] CMD_ALLOC = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // Configuration register indexes
  localparam int         CFG_IDX_W       = 1;
  localparam logic [0:0] REG_ENTRY_COUNT = 1'd0;
  localparam logic [0:0] REG_INDEX_BASE  = 1'd1;

  // Status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_NONE = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] entry_count;
    logic             index_base;
  } cfg_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [ADDR_W-1:0]    raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> hdl/bffa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bffa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/bffa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bffa_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire bffa_pkg::cfg_t               cfg,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   cmd,
  input  wire logic [bffa_pkg::IDX_W-1:0]   bit_index,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              status,
  output logic [bffa_pkg::CNT_W-1:0]        found_index,
  output bffa_pkg::mem_req_t                mem_req,
  input  wire logic [bffa_pkg::WORD_BITS-1:0] mem_rdata
);

  import bffa_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]           state;
  logic [ADDR_W-1:0]    clr_cnt;
  logic [ADDR_W-1:0]    chk_w;
  logic [1:0]           cmd_q;
  logic [IDX_W-1:0]     bit_q;
  logic                 res_status;
  logic [CNT_W-1:0]     res_found;

  logic [CNT_W-1:0]     limit;
  logic [CNT_W-1:0]     limit_up;
  logic [NWORD_W-1:0]   nwords;
  logic [ADDR_W-1:0]    last_w;
  logic [WORD_BITS-1:0] tail_mask;
  logic [WORD_BITS-1:0] eff_word;
  logic                 is_last;
  logic                 hit;
  logic [BIT_W-1:0]     hit_bit;
  logic [IDX_W-1:0]     hit_pos;
  logic                 in_acc;
  logic                 out_free;

  // Lowest clear bit of a word
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // Search limit and the words it covers
  always_comb begin
    limit    = (cfg.entry_count > CNT_W'(MAP_BITS)) ? CNT_W'(MAP_BITS) : cfg.entry_count;
    limit_up = limit + CNT_W'(WORD_BITS - 1);
    nwords   = limit_up[BIT_W +: NWORD_W];
    last_w   = ADDR_W'(nwords - NWORD_W'(1));
    if (limit[BIT_W-1:0] == '0) begin
      tail_mask = '1;
    end else begin
      tail_mask = (WORD_BITS'(1) << limit[BIT_W-1:0]) - WORD_BITS'(1);
    end
  end

  // Evaluate the word that has just been read
  always_comb begin
    is_last  = (chk_w == last_w);
    eff_word = mem_rdata | (is_last ? ~tail_mask : '0);
    hit      = (eff_word != '1);
    hit_bit  = first_zero(eff_word);
    hit_pos  = {chk_w, hit_bit};
  end

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Memory requests
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = chk_w;
    mem_req.wdata = mem_rdata;
    mem_req.raddr = '0;
    unique case (state)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_cnt;
        mem_req.wdata = '0;
      end
      S_IDLE: begin
        mem_req.raddr = (cmd == CMD_MARK) ? bit_index[IDX_W-1:BIT_W] : '0;
      end
      S_SCAN: begin
        mem_req.raddr = chk_w + ADDR_W'(1);
        mem_req.we    = hit && (cmd_q == CMD_ALLOC);
        mem_req.wdata = mem_rdata | (WORD_BITS'(1) << hit_bit);
      end
      S_MARK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = bit_q[IDX_W-1:BIT_W];
        mem_req.wdata = mem_rdata | (WORD_BITS'(1) << bit_q[BIT_W-1:0]);
      end
      S_DONE: begin
        mem_req.we = 1'b0;
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == ADDR_W'(MAP_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            cmd_q <= cmd;
            bit_q <= bit_index;
            chk_w <= '0;
            res_status <= ST_OK;
            res_found  <= '0;
            case (cmd) inside
              CMD_FIND, CMD_ALLOC: begin
                if (nwords == '0) begin
                  res_status <= ST_NONE;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_MARK: state <= S_MARK;
              default:  state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            res_status <= ST_OK;
            res_found  <= CNT_W'(hit_pos) + CNT_W'(cfg.index_base);
            state      <= S_DONE;
          end else if (is_last) begin
            res_status <= ST_NONE;
            res_found  <= '0;
            state      <= S_DONE;
          end else begin
            chk_w <= chk_w + ADDR_W'(1);
          end
        end
        S_MARK: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status      <= res_status;
      found_index <= res_found;
    end
  end

endmodule

`default_nettype wire

>>> hdl/bitmap_first_fit_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// First-fit bitmap allocator over 32768 entries held as 1024 words of 32 bits in one
// synchronous RAM (one write port, one registered read port). After reset the block
// runs a clearing pass, writing every word to zero, and holds in_stall high until it
// is done; configuration writes are taken at any time (cfg_ready is always high). Find
// (cmd 0) and allocate (cmd 2) read one word per cycle from word 0 up until the first
// clear entry turns up; the number of words read is at most
// ceil(min(entry_count, 32768) / 32). Mark (cmd 1) is a read-modify-write of one word;
// cmd 3 and a search with entry_count of zero go straight to the result. One item is
// worked on at a time; the finished result sits in an output register, so the next
// item is accepted while it waits.
module bitmap_first_fit_allocator_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bffa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bffa_pkg::CNT_W-1:0]      cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      cmd,
  input  wire logic [bffa_pkg::IDX_W-1:0]      bit_index,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 status,
  output logic [bffa_pkg::CNT_W-1:0]           found_index
);

  import bffa_pkg::*;

  cfg_t                 cfg;
  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] mem_rdata;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entry_count <= CNT_W'(MAP_BITS);
      cfg.index_base  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENTRY_COUNT: cfg.entry_count <= cfg_data;
        REG_INDEX_BASE:  cfg.index_base  <= cfg_data[0];
        default:         cfg.index_base  <= cfg.index_base;
      endcase
    end
  end

  bffa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .bit_index   (bit_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_index (found_index),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata)
  );

  bffa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

>>> hdl/bffa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bffa_props (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic                            status,
  input wire logic [bffa_pkg::CNT_W-1:0]      found_index
);

  import bffa_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(found_index))
    else $error("stalled result changed");

  // A failed search reports index zero
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NONE |-> found_index == '0)
    else $error("nonzero index with no free entry");

  // One item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while busy");

  // Clearing pass follows reset
  a_clear_after_rst: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("block ready straight after reset");

endmodule

bind bitmap_first_fit_allocator_core bffa_props u_bffa_checker (.*);

`default_nettype wire

>>> tb/sv/bffa_checker.sv
`timescale 1ns / 1ps

// Watches the config, command and result channels of the allocator, keeps its own
// copy of the allocation bitmap and registers, and checks every result in order.
module bffa_checker
  import bffa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire logic [1:0]           cmd,
  input  wire logic [IDX_W-1:0]     bit_index,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire logic                 status,
  input  wire logic [CNT_W-1:0]     found_index,
  output int                        errors,
  output int                        results_seen
);

  typedef struct packed {
    logic             status;
    logic [CNT_W-1:0] found;
  } alloc_result_t;

  logic [WORD_BITS-1:0] used_words [MAP_WORDS];
  logic [CNT_W-1:0]     search_count;
  logic                 index_offset;
  alloc_result_t        owed_results [$];

  // Scan from entry 0 for the lowest clear bit below the search limit
  function automatic logic lowest_free(output int pos);
    int limit;
    pos = 0;
    limit = (int'(search_count) > MAP_BITS) ? MAP_BITS : int'(search_count);
    for (int w = 0; w * WORD_BITS < limit; w++) begin
      if (used_words[w] != '1) begin
        for (int b = 0; b < WORD_BITS; b++) begin
          if (w * WORD_BITS + b >= limit) return 1'b0;
          if (!used_words[w][b]) begin
            pos = w * WORD_BITS + b;
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // Apply one command to the bitmap and return the result it owes
  function automatic alloc_result_t apply_command(logic [1:0] c, logic [IDX_W-1:0] b);
    alloc_result_t r;
    int pos;
    r.status = ST_OK;
    r.found  = '0;
    case (c)
      CMD_FIND, CMD_ALLOC: begin
        if (lowest_free(pos)) begin
          r.found = CNT_W'(pos + int'(index_offset));
          if (c == CMD_ALLOC) used_words[pos / WORD_BITS][pos % WORD_BITS] = 1'b1;
        end else begin
          r.status = ST_NONE;
        end
      end
      CMD_MARK: begin
        // index base never shifts the marked bit
        if (int'(b) < MAP_BITS) used_words[int'(b) / WORD_BITS][int'(b) % WORD_BITS] = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_failure(input string what);
    if (errors < 10) $display("checker: %s", what);
    errors <= errors + 1;
  endtask

  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (rst) begin
      for (int w = 0; w < MAP_WORDS; w++) used_words[w] = '0;
      search_count = CNT_W'(32768);
      index_offset = 1'b0;
      owed_results.delete();
    end else begin
      // retire a result before taking a new item: it belongs to an older one
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        got.status = status;
        got.found  = found_index;
        if (owed_results.size() == 0) begin
          note_failure($sformatf("result %0d with nothing expected: status %0b found %0d",
                                 results_seen, got.status, got.found));
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status || got.found !== want.found)
            note_failure($sformatf(
              "result %0d: status exp %0b got %0b, found_index exp %0d got %0d",
              results_seen, want.status, got.status, want.found, got.found));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENTRY_COUNT: search_count = cfg_data;
          REG_INDEX_BASE:  index_offset = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) owed_results.push_back(apply_command(cmd, bit_index));
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import bffa_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 48;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           cmd = CMD_FIND;
  logic [IDX_W-1:0]     bit_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 status;
  logic [CNT_W-1:0]     found_index;

  int errors;
  int results_seen;
  int items_sent = 0;
  int reg_writes = 0;
  int cmd_tally [4] = '{0, 0, 0, 0};
  int cycle_count = 0;
  int stall_left = 0;
  bit send_gaps = 1'b0;
  bit stall_on = 1'b0;

  always #1 clk = ~clk;

  bitmap_first_fit_allocator_core DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .bit_index(bit_index),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .found_index(found_index)
  );

  bffa_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .bit_index(bit_index),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .found_index(found_index),
    .errors(errors), .results_seen(results_seen)
  );

  // Hold off results for a drawn number of cycles after each one is taken
  always @(posedge clk) begin
    if (out_valid && !out_stall) stall_left = stall_on ? $urandom_range(0, 16) : 0;
    else if (stall_left > 0) stall_left--;
    out_stall <= (stall_left > 0);
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: timeout at cycle %0d, %0d of %0d results in", cycle_count,
               results_seen, items_sent);
      $display("tb: done, errors");
      $finish;
    end
  end

  // Offer one item after a drawn gap and hold it until taken
  task automatic send_item(input logic [1:0] c, input logic [IDX_W-1:0] b);
    int gap;
    gap = send_gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    bit_index <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    cmd_tally[c]++;
  endtask

  // Wait for every owed result, then write one register
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    in_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_base(input logic base);
    set_reg(REG_INDEX_BASE, (CNT_W'($urandom) & ~CNT_W'(1)) | CNT_W'(base));
  endtask

  // Mostly allocate and mark near the filled region so searches walk past full words
  task automatic send_random_item();
    int pick;
    logic [IDX_W-1:0] b;
    pick = $urandom_range(0, 19);
    b = ($urandom_range(0, 9) < 7) ? IDX_W'($urandom_range(0, 511)) : IDX_W'($urandom);
    if (pick < 8)       send_item(CMD_ALLOC, b);
    else if (pick < 13) send_item(CMD_FIND, b);
    else if (pick < 18) send_item(CMD_MARK, b);
    else                send_item(CMD_NOP, b);
  endtask

  initial begin
    logic [CNT_W-1:0] count;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty map, repeated and top-bit marks, no-ops
    send_gaps = 1'b1;
    stall_on  = 1'b1;
    send_item(CMD_FIND, '0);
    send_item(CMD_ALLOC, '1);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_MARK, IDX_W'(2));
    send_item(CMD_MARK, IDX_W'(2));
    send_item(CMD_FIND, '0);
    send_item(CMD_MARK, '1);
    send_item(CMD_NOP, '1);
    send_item(CMD_NOP, '0);
    send_item(CMD_FIND, '1);

    // Directed: nothing searched, a full small range, then base 1 over a huge count
    set_reg(REG_ENTRY_COUNT, '0);
    send_item(CMD_FIND, '0);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_MARK, IDX_W'(3));
    set_reg(REG_ENTRY_COUNT, CNT_W'(4));
    send_item(CMD_FIND, '0);
    send_item(CMD_ALLOC, '0);
    set_reg(REG_ENTRY_COUNT, '1);
    set_base(1'b1);
    send_item(CMD_FIND, '0);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_MARK, IDX_W'(5));
    send_item(CMD_ALLOC, '0);
    send_item(CMD_FIND, '0);
    send_item(CMD_NOP, IDX_W'(16'h5555));

    // Random phases, each under its own register setting and idling mix
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: count = '1;
        1: count = '0;
        2: count = CNT_W'(MAP_BITS);
        default: begin
          case ($urandom_range(0, 4))
            0: count = CNT_W'($urandom_range(1, 64));
            1: count = CNT_W'($urandom_range(1, 400));
            2: count = CNT_W'(MAP_BITS);
            3: count = '1;
            default: count = CNT_W'($urandom);
          endcase
        end
      endcase
      set_reg(REG_ENTRY_COUNT, count);
      set_base((p < 2) ? p[0] : 1'($urandom));
      send_gaps = ($urandom_range(0, 2) != 0);
      stall_on  = ($urandom_range(0, 2) != 0);
      for (int k = 0; k < PHASE_ITEMS; k++) send_random_item();
    end
    in_valid <= 1'b0;

    // Drain, then let the block sit long enough to show any stray result
    while (results_seen != items_sent) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("tb: %0d items under %0d register writes (find %0d, mark %0d, alloc %0d, nop %0d)",
             items_sent, reg_writes, cmd_tally[CMD_FIND], cmd_tally[CMD_MARK],
             cmd_tally[CMD_ALLOC], cmd_tally[CMD_NOP]);
    $display("tb: %0d results checked, %0d mismatched, %0d cycles", results_seen, errors,
             cycle_count);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
